### rtl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types, constants and activation tables for the LSTM cell step block.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int DefaultCells = 64;
  localparam int IdxW         = 6;
  localparam int DataW        = 16;
  localparam int HidW         = 14;

  typedef logic signed [DataW-1:0] q412_t;
  typedef logic signed [DataW-1:0] tab_t [256];

  // one input transaction as it travels down the pipe
  typedef struct packed {
    logic [IdxW-1:0] cell_index;
    logic            seq_start;
    q412_t           in_gate_pre;
    q412_t           forget_gate_pre;
    q412_t           cell_pre;
    q412_t           out_gate_pre;
    q412_t           in_peep_weight;
    q412_t           out_peep_weight;
  } item_t;

  localparam logic [63:0] OneQ60 = 64'd1 << 60;

  // shift-subtract divide, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(scale / (1 + p)), p = e^-t in Q60
  function automatic logic [63:0] logistic_round(input logic [63:0] scale,
                                                 input logic [63:0] p);
    logic [63:0] q;
    q = (OneQ60 + p) >> 20;
    return udiv64((scale << 41) + q, q << 1);
  endfunction

  // sigmoid table (want_tanh = 0) or tanh table (want_tanh = 1)
  function automatic tab_t build_tab(input logic want_tanh);
    tab_t         t;
    logic [63:0]  term;
    logic [63:0]  d;
    logic [63:0]  p;
    logic [127:0] prod;
    logic [63:0]  s;
    int           idx;
    int           m;
    for (int i = 0; i < 256; i++) t[i] = '0;
    term = OneQ60;
    d    = OneQ60;
    p    = OneQ60;
    for (int k = 1; k <= 14; k++) begin
      term = udiv64(term, 64'(32 * k));
      if ((k & 1) != 0) d = d - term;
      else d = d + term;
    end
    for (int n = 1; n <= 510; n++) begin
      prod = {64'd0, p} * {64'd0, d};
      p    = prod[123:60];
      if (!want_tanh && ((n & 1) != 0) && n <= 255) begin
        idx            = (n + 255) >> 1;
        s              = logistic_round(64'd4096, p);
        t[idx]         = DataW'(s);
        t[255 - idx]   = DataW'(64'd4096 - s);
      end
      if (want_tanh && ((n & 3) == 2)) begin
        m              = n >> 1;
        idx            = (m + 255) >> 1;
        s              = logistic_round(64'd8192, p) - 64'd4096;
        t[idx]         = DataW'(s);
        t[255 - idx]   = DataW'(64'd0 - s);
      end
    end
    return t;
  endfunction

  localparam tab_t SigTab  = build_tab(1'b0);
  localparam tab_t TanhTab = build_tab(1'b1);

  // clamp to Q4.12 range and take the top byte with the sign flipped
  function automatic logic [7:0] tab_idx(input logic signed [23:0] x);
    logic [7:0] k;
    if (x < -24'sd32768) k = 8'd0;
    else if (x > 24'sd32767) k = 8'd255;
    else k = x[15:8] ^ 8'h80;
    return k;
  endfunction

endpackage

### rtl/lcs_if.sv
// ----------------------------------------------------------------------------
// lcs_in_if / lcs_out_if
// Valid/ready channels for gate transactions and cell results.
// ----------------------------------------------------------------------------
interface lcs_in_if;
  import lcs_pkg::*;
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] cell_index;
  logic            seq_start;
  q412_t           in_gate_pre;
  q412_t           forget_gate_pre;
  q412_t           cell_pre;
  q412_t           out_gate_pre;
  q412_t           in_peep_weight;
  q412_t           out_peep_weight;

  modport source (output valid, cell_index, seq_start, in_gate_pre, forget_gate_pre,
                  cell_pre, out_gate_pre, in_peep_weight, out_peep_weight,
                  input ready);
  modport sink (input valid, cell_index, seq_start, in_gate_pre, forget_gate_pre,
                cell_pre, out_gate_pre, in_peep_weight, out_peep_weight,
                output ready);
endinterface

interface lcs_out_if;
  import lcs_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [IdxW-1:0]        cell_index_out;
  logic signed [HidW-1:0] hidden_out;
  q412_t                  new_state;

  modport source (output valid, cell_index_out, hidden_out, new_state, input ready);
  modport sink (input valid, cell_index_out, hidden_out, new_state, output ready);
endinterface

### rtl/lcs_state_mem.sv
// ----------------------------------------------------------------------------
// lcs_state_mem
// Per-cell state store: one write port, one registered read port, reads as
// zero until an entry is first written after reset.
// ----------------------------------------------------------------------------
module lcs_state_mem
  import lcs_pkg::*;
#(
  parameter int CELLS = DefaultCells,
  localparam int AW   = (CELLS > 1) ? $clog2(CELLS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output q412_t         rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  q412_t         wr_data
);

  q412_t            mem [CELLS];
  logic [CELLS-1:0] written_r;
  q412_t            rd_word_r;
  logic             rd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      rd_hit_r  <= 1'b0;
    end else begin
      if (wr_en) written_r[wr_addr] <= 1'b1;
      if (rd_en) rd_hit_r <= written_r[rd_addr];
    end
  end

  assign rd_data = rd_hit_r ? rd_word_r : '0;

endmodule

### rtl/lstm_cell_step.sv
// ----------------------------------------------------------------------------
// lstm_cell_step
// LSTM memory-cell update with optional peepholes, Q4.12 fixed point,
// eight-stage pipeline with a per-cell state store.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  in_ch     in   valid/ready     cell_index, seq_start, 4 gate pre-acts, 2 peep weights
//  out_ch    out  valid/ready     cell_index_out, hidden_out, new_state
//  cfg_*     in   cfg_we strobe   cfg_wdata = peephole_enable
//
// One transaction per cycle while out_ch is ready and no same-cell wait holds the input.
// A transaction whose cell (not on a sequence start) matches one still in stages
// 1..4 waits until that one has written its state: the loop is read, peephole
// multiply, gate lookup, gate products, state sum. Reset clears valid bits, the config
// register and the store's written flags at once (no clearing pass). A stalled output
// backs up stage by stage; bubbles collapse, nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module lstm_cell_step
  import lcs_pkg::*;
#(
  parameter int CELLS = DefaultCells
) (
  input  logic          clk,
  input  logic          rst_n,
  lcs_in_if.sink        in_ch,
  lcs_out_if.source     out_ch,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  localparam int SW = (CELLS > 1) ? $clog2(CELLS) : 1;

  // cell index -> store slot (index mod CELLS)
  logic [SW-1:0] slot_lut [2**IdxW];
  for (genvar g = 0; g < 2**IdxW; g++) begin : g_slot
    assign slot_lut[g] = SW'(g % CELLS);
  end

  logic peep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) peep_r <= 1'b0;
    else if (cfg_we) peep_r <= cfg_wdata;
  end

  // stage valids and data
  logic [7:0] v_r;
  logic [8:0] rdy;          // rdy[k]: stage k+1 may load, rdy[7]: output register
  item_t d1_r, d2_r, d3_r, d4_r, d5_r, d6_r, d7_r;

  assign rdy[8] = out_ch.ready;
  for (genvar k = 0; k < 8; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end
  // v_r[0] = stage 1 ... v_r[6] = stage 7, v_r[7] = output register

  // ---------------- input and hazard check ----------------
  item_t   in_item;
  logic    hazard;
  logic    in_acc;
  logic [SW-1:0] in_slot;

  assign in_item = '{cell_index: in_ch.cell_index, seq_start: in_ch.seq_start,
                     in_gate_pre: in_ch.in_gate_pre,
                     forget_gate_pre: in_ch.forget_gate_pre,
                     cell_pre: in_ch.cell_pre, out_gate_pre: in_ch.out_gate_pre,
                     in_peep_weight: in_ch.in_peep_weight,
                     out_peep_weight: in_ch.out_peep_weight};
  assign in_slot = slot_lut[in_ch.cell_index];

  // an older transaction on the same cell that has not yet written its state
  assign hazard = !in_ch.seq_start && (
      (v_r[0] && slot_lut[d1_r.cell_index] == in_slot) ||
      (v_r[1] && slot_lut[d2_r.cell_index] == in_slot) ||
      (v_r[2] && slot_lut[d3_r.cell_index] == in_slot) ||
      (v_r[3] && slot_lut[d4_r.cell_index] == in_slot));

  assign in_ch.ready = rdy[0] && !hazard;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // ---------------- state store ----------------
  q412_t c_prev_rd;
  q412_t c4;
  logic  st_wr;

  assign st_wr = v_r[3] && rdy[4];

  lcs_state_mem #(.CELLS(CELLS)) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (in_slot),
    .rd_data (c_prev_rd),
    .wr_en   (st_wr),
    .wr_addr (slot_lut[d4_r.cell_index]),
    .wr_data (c4)
  );

  // ---------------- stage 1: previous state, input peephole product ----------
  q412_t              cprev1;
  logic signed [31:0] pin1;
  assign cprev1 = d1_r.seq_start ? '0 : c_prev_rd;
  // signed zero keeps the product signed
  assign pin1   = peep_r ? d1_r.in_peep_weight * cprev1 : 32'sd0;

  // ---------------- stage 2: gate lookups ----------------
  q412_t              cprev2_r;
  logic signed [31:0] pin2_r;
  logic signed [23:0] isum2;
  q412_t              ig2, fg2, gc2;
  assign isum2 = 24'(d2_r.in_gate_pre) + 24'(pin2_r >>> 12);
  assign ig2   = SigTab[tab_idx(isum2)];
  assign fg2   = SigTab[tab_idx(24'(d2_r.forget_gate_pre))];
  assign gc2   = TanhTab[tab_idx(24'(d2_r.cell_pre))];

  // ---------------- stage 3: gate products ----------------
  q412_t              ig3_r, fg3_r, gc3_r, cprev3_r;
  logic signed [31:0] p1_3, p2_3;
  assign p1_3 = ig3_r * gc3_r;
  assign p2_3 = fg3_r * cprev3_r;

  // ---------------- stage 4: state sum and saturation ----------------
  logic signed [31:0] p1_4_r, p2_4_r;
  logic signed [32:0] csum4;
  logic signed [20:0] csh4;
  assign csum4 = 33'(p1_4_r) + 33'(p2_4_r);
  assign csh4  = 21'(csum4 >>> 12);
  always_comb begin
    if (csh4 > 21'sd32767) c4 = 16'sd32767;
    else if (csh4 < -21'sd32768) c4 = 16'sh8000;
    else c4 = csh4[15:0];
  end

  // ---------------- stage 5: output peephole product, tanh(c) ----------
  q412_t              c5_r;
  logic signed [31:0] pout5;
  q412_t              tc5;
  assign pout5 = peep_r ? d5_r.out_peep_weight * c5_r : 32'sd0;
  assign tc5   = TanhTab[tab_idx(24'(c5_r))];

  // ---------------- stage 6: output gate ----------------
  q412_t              c6_r, tc6_r;
  logic signed [31:0] pout6_r;
  logic signed [23:0] osum6;
  q412_t              og6;
  assign osum6 = 24'(d6_r.out_gate_pre) + 24'(pout6_r >>> 12);
  assign og6   = SigTab[tab_idx(osum6)];

  // ---------------- stage 7: hidden output ----------------
  q412_t              c7_r, tc7_r, og7_r;
  logic signed [31:0] hp7;
  assign hp7 = og7_r * tc7_r;

  logic [IdxW-1:0]        oidx_r;
  logic signed [HidW-1:0] oh_r;
  q412_t                  oc_r;

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) d1_r <= in_item;
    if (v_r[0] && rdy[1]) begin
      d2_r <= d1_r; cprev2_r <= cprev1; pin2_r <= pin1;
    end
    if (v_r[1] && rdy[2]) begin
      d3_r <= d2_r; ig3_r <= ig2; fg3_r <= fg2; gc3_r <= gc2; cprev3_r <= cprev2_r;
    end
    if (v_r[2] && rdy[3]) begin
      d4_r <= d3_r; p1_4_r <= p1_3; p2_4_r <= p2_3;
    end
    if (v_r[3] && rdy[4]) begin
      d5_r <= d4_r; c5_r <= c4;
    end
    if (v_r[4] && rdy[5]) begin
      d6_r <= d5_r; c6_r <= c5_r; tc6_r <= tc5; pout6_r <= pout5;
    end
    if (v_r[5] && rdy[6]) begin
      d7_r <= d6_r; c7_r <= c6_r; tc7_r <= tc6_r; og7_r <= og6;
    end
    if (v_r[6] && rdy[7]) begin
      oidx_r <= d7_r.cell_index;
      oh_r   <= HidW'(hp7 >>> 12);
      oc_r   <= c7_r;
    end
  end

  // valid bits
  logic [7:0] v_nxt;
  always_comb begin
    v_nxt[0] = in_acc || (v_r[0] && !rdy[1]);
    for (int k = 1; k < 8; k++) begin
      v_nxt[k] = (v_r[k-1] && rdy[k]) || (v_r[k] && !rdy[k+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= v_nxt;
  end

  assign out_ch.valid          = v_r[7];
  assign out_ch.cell_index_out = oidx_r;
  assign out_ch.hidden_out     = oh_r;
  assign out_ch.new_state      = oc_r;

  // ---------------- assertions ----------------
  // interlock: a reading transaction in stage 1 never overlaps a same-cell
  // transaction in stage 2, which has yet to write its state
  a_no_raw: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[0] && !d1_r.seq_start && v_r[1]) |->
      (slot_lut[d1_r.cell_index] != slot_lut[d2_r.cell_index]))
    else $error("state read overlaps pending write");

  // hidden output stays within +/-1.0
  a_h_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.hidden_out >= -14'sd4096) && (out_ch.hidden_out <= 14'sd4096))
    else $error("hidden_out out of range");

  // a state write always comes from a transaction leaving stage 4
  a_wr_move: assert property (@(posedge clk) disable iff (!rst_n)
    st_wr |=> v_r[4])
    else $error("state write without stage 5 load");

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for lstm_cell_step: drives gate transactions with random
// idling and stalls, predicts each cell update in a scoreboard and compares
// every result field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import lcs_pkg::*;

  // expected result of one transaction
  typedef struct {
    logic [IdxW-1:0]        cidx;
    logic signed [HidW-1:0] hidden;
    q412_t                  state;
  } cell_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the activation tables, state store and peephole
  // flag; predicts on every accepted input, checks on every accepted result
  // --------------------------------------------------------------------------
  class lstm_scoreboard;
    logic signed [15:0] sig_lut[256];
    logic signed [15:0] tanh_lut[256];
    longint             state_mem[64];
    bit                 peep_on;
    cell_result_t       pending[$];
    int                 errors;

    function new();
      logic [63:0]  one_q;
      logic [63:0]  term;
      logic [63:0]  decay;
      logic [63:0]  pw;
      logic [127:0] prod;
      logic [63:0]  s;
      int           idx;
      one_q = 64'd1 << 60;
      term  = one_q;
      decay = one_q;
      pw    = one_q;
      // e^(-1/32) in Q60 by its Taylor series
      for (int k = 1; k <= 14; k++) begin
        term = term / 64'(32 * k);
        if (k % 2 == 1) decay = decay - term;
        else decay = decay + term;
      end
      for (int n = 1; n <= 510; n++) begin
        prod = {64'd0, pw} * {64'd0, decay};
        pw   = prod[123:60];
        if (n % 2 == 1 && n <= 255) begin
          idx               = (n + 255) / 2;
          s                 = logistic_q(64'd4096, pw);
          sig_lut[idx]       = 16'(s);
          sig_lut[255 - idx] = 16'(64'd4096 - s);
        end
        if (n % 4 == 2) begin
          idx                = (n / 2 + 255) / 2;
          s                  = logistic_q(64'd8192, pw) - 64'd4096;
          tanh_lut[idx]       = 16'(s);
          tanh_lut[255 - idx] = 16'(64'd0 - s);
        end
      end
      foreach (state_mem[i]) state_mem[i] = 0;
      peep_on = 0;
      errors  = 0;
    endfunction

    // round(scale / (1 + p)), p in Q60
    function logic [63:0] logistic_q(logic [63:0] scale, logic [63:0] p);
      logic [63:0] q;
      q = ((64'd1 << 60) + p) >> 20;
      return ((scale << 41) + q) / (q << 1);
    endfunction

    function int lut_slot(longint x);
      if (x < -32768) x = -32768;
      if (x > 32767) x = 32767;
      return int'((x + 32768) >> 8);
    endfunction

    function void note_input(item_t it);
      longint       c_prev, in_arg, out_arg, ig, fg, gc, og, c, h;
      cell_result_t r;
      c_prev  = it.seq_start ? 0 : state_mem[it.cell_index];
      in_arg  = longint'(it.in_gate_pre);
      out_arg = longint'(it.out_gate_pre);
      if (peep_on) in_arg += (longint'(it.in_peep_weight) * c_prev) >>> 12;
      ig = sig_lut[lut_slot(in_arg)];
      fg = sig_lut[lut_slot(longint'(it.forget_gate_pre))];
      gc = tanh_lut[lut_slot(longint'(it.cell_pre))];
      c  = (ig * gc + fg * c_prev) >>> 12;
      if (c > 32767) c = 32767;
      if (c < -32768) c = -32768;
      if (peep_on) out_arg += (longint'(it.out_peep_weight) * c) >>> 12;
      og = sig_lut[lut_slot(out_arg)];
      h  = (og * longint'(tanh_lut[lut_slot(c)])) >>> 12;
      state_mem[it.cell_index] = c;
      r.cidx   = it.cell_index;
      r.hidden = HidW'(h);
      r.state  = DataW'(c);
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(logic [IdxW-1:0] cidx, logic signed [HidW-1:0] hidden,
                               q412_t state);
      cell_result_t r;
      if (pending.size() == 0) begin
        report_err("result with nothing pending", 0, cidx);
        return;
      end
      r = pending.pop_front();
      if (cidx !== r.cidx) report_err("cell_index_out", r.cidx, cidx);
      if (hidden !== r.hidden) report_err("hidden_out", r.hidden, hidden);
      if (state !== r.state) report_err("new_state", r.state, state);
    endfunction

    function void report_err(string what, longint want, longint got);
      errors++;
      $display("MISMATCH %s: expected %0d got %0d at %0t", what, want, got, $time);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, channels, DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  always #1 clk = ~clk;

  lcs_in_if  in_ch ();
  lcs_out_if out_ch ();

  lstm_cell_step dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lstm_scoreboard sb = new();

  int send_idle_pct  = 0;   // sender idle chance per cycle
  int recv_stall_pct = 0;   // receiver stall chance per cycle
  int hold_off       = 0;   // long receiver hold-off, counted down by the receiver
  int quiet_cycles   = 0;

  // receiver: ready changes at the falling edge only
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ch.ready = 1'b0;
      hold_off     = hold_off - 1;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.cell_index_out, out_ch.hidden_out, out_ch.new_state);
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // Q4.12 value: mostly inside the table range, sometimes anywhere or extreme
  function automatic q412_t pick_q412();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      1, 2, 3: return q412_t'($urandom_range(65535));
      default: return q412_t'(int'($urandom_range(16383)) - 8192);
    endcase
  endfunction

  function automatic item_t pick_item();
    item_t it;
    it.cell_index      = ($urandom_range(3) == 0) ? IdxW'($urandom_range(63))
                                                  : IdxW'($urandom_range(7));
    it.seq_start       = ($urandom_range(9) == 0);
    it.in_gate_pre     = pick_q412();
    it.forget_gate_pre = pick_q412();
    it.cell_pre        = pick_q412();
    it.out_gate_pre    = pick_q412();
    it.in_peep_weight  = pick_q412();
    it.out_peep_weight = pick_q412();
    return it;
  endfunction

  function automatic item_t make_item(int cidx, bit start, q412_t v, q412_t w);
    item_t it;
    it.cell_index      = IdxW'(cidx);
    it.seq_start       = start;
    it.in_gate_pre     = v;
    it.forget_gate_pre = v;
    it.cell_pre        = v;
    it.out_gate_pre    = v;
    it.in_peep_weight  = w;
    it.out_peep_weight = w;
    return it;
  endfunction

  // present one transaction from a falling edge and hold until accepted
  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid           = 1'b1;
    in_ch.cell_index      = it.cell_index;
    in_ch.seq_start       = it.seq_start;
    in_ch.in_gate_pre     = it.in_gate_pre;
    in_ch.forget_gate_pre = it.forget_gate_pre;
    in_ch.cell_pre        = it.cell_pre;
    in_ch.out_gate_pre    = it.out_gate_pre;
    in_ch.in_peep_weight  = it.in_peep_weight;
    in_ch.out_peep_weight = it.out_peep_weight;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // wait for every pending result, then let the pipe settle
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_peep(bit value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.peep_on = value;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.cell_index      = '0;
    in_ch.seq_start       = 1'b0;
    in_ch.in_gate_pre     = '0;
    in_ch.forget_gate_pre = '0;
    in_ch.cell_pre        = '0;
    in_ch.out_gate_pre    = '0;
    in_ch.in_peep_weight  = '0;
    in_ch.out_peep_weight = '0;
    out_ch.ready          = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: peepholes on, extremes, recurrence on one cell, sequence start
    write_peep(1'b1);
    send_item(make_item(0, 1'b0, 16'sh7fff, 16'sh7fff));   // state from reset zero
    send_item(make_item(0, 1'b0, 16'sh7fff, 16'sh7fff));   // grows, peep sum clamps
    send_item(make_item(0, 1'b0, 16'sh7fff, 16'sh7fff));
    send_item(make_item(0, 1'b0, 16'sh8000, 16'sh8000));   // big negative peep sum
    send_item(make_item(0, 1'b1, 16'sh8000, 16'sh7fff));   // sequence start
    send_item(make_item(63, 1'b0, 16'sh8000, 16'sh8000));
    send_item(make_item(63, 1'b0, 16'sh8000, 16'sh7fff));
    send_item(make_item(63, 1'b0, 16'sh0000, 16'sh0000));
    send_item(make_item(5, 1'b0, 16'sh1000, 16'shf000));
    send_item(make_item(5, 1'b0, 16'shffff, 16'sh0001));
    send_item(make_item(5, 1'b1, 16'sh00ff, 16'sh0100));
    send_item(make_item(42, 1'b0, 16'sh7f00, 16'sh80ff));
    drain();
    // directed: peepholes off, same cells carry state over
    write_peep(1'b0);
    send_item(make_item(0, 1'b0, 16'sh7fff, 16'sh7fff));
    send_item(make_item(63, 1'b0, 16'sh8000, 16'sh7fff));
    send_item(make_item(5, 1'b1, 16'sh0000, 16'sh8000));
    send_item(make_item(5, 1'b0, 16'sh0800, 16'sh8000));
    send_item(make_item(21, 1'b0, 16'shff00, 16'sh0000));
    drain();

    // random phases: peep setting x idling mode
    for (int ph = 0; ph < 8; ph++) begin
      write_peep(ph % 2 == 0);
      case (ph / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      for (int n = 0; n < 140; n++) begin
        // long receiver hold-off while the sender keeps pushing
        if (ph == 0 && n == 30) hold_off = 300;
        // sender waits for every pending result once
        if (ph == 1 && n == 70)
          while (sb.pending.size() != 0) @(negedge clk);
        send_item(pick_item());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
